// ===== hdl/okvt_pkg.sv =====
// ---------------------------------------------------------------------------
// okvt_pkg: shared types and constants for the ordered key/value table
// Item layouts, operation and status codes, and the cell link structs.
// ---------------------------------------------------------------------------
package okvt_pkg;

   localparam int DEPTH      = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CNT_BITS   = $clog2(DEPTH + 1);

   // operation codes
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_FIND   = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [3:0] {
      ST_INSERTED     = 4'd0,
      ST_DUP          = 4'd1,
      ST_FULL         = 4'd2,
      ST_POPPED       = 4'd3,
      ST_EMPTY        = 4'd4,
      ST_REMOVED      = 4'd5,
      ST_KEY_ABSENT   = 4'd6,
      ST_FOUND        = 4'd7,
      ST_VALUE_ABSENT = 4'd8
   } status_type;

   // input item
   typedef struct packed {
      op_type                  op;
      logic [KEY_BITS-1:0]     key;
      logic [VALUE_BITS-1:0]   value;
   } req_type;

   // result item
   typedef struct packed {
      status_type              status;
      logic [KEY_BITS-1:0]     key_out;
      logic [CNT_BITS-1:0]     count;
   } rsp_type;

   // per-cell write controls, shared by the whole row
   typedef struct packed {
      logic ins_en;
      logic rem_en;
   } ctrl_type;

   // match status handed from cell to cell, oldest to newest
   typedef struct packed {
      logic key_seen;
      logic val_seen;
   } link_type;

endpackage

// ===== hdl/okvt_cell.sv =====
// ---------------------------------------------------------------------------
// okvt_cell: one entry of the ordered key/value table
// Holds a key/value pair, compares it with the item, passes match status
// to the next newer cell and takes its neighbor's pair on a remove.
// ---------------------------------------------------------------------------
module okvt_cell (
   input  logic                              clock,
   input  okvt_pkg::ctrl_type                ctrl,
   input  logic                              occupied,
   input  logic                              is_tail,
   input  logic [okvt_pkg::KEY_BITS-1:0]     req_key,
   input  logic [okvt_pkg::VALUE_BITS-1:0]   req_value,
   input  logic [okvt_pkg::KEY_BITS-1:0]     nbr_key,
   input  logic [okvt_pkg::VALUE_BITS-1:0]   nbr_value,
   input  okvt_pkg::link_type                link_in,
   output okvt_pkg::link_type                link_out,
   output logic                              val_first,
   output logic [okvt_pkg::KEY_BITS-1:0]     key_q,
   output logic [okvt_pkg::VALUE_BITS-1:0]   value_q
);

   logic [okvt_pkg::KEY_BITS-1:0]   key_ff,   key_in;
   logic [okvt_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic                            key_hit;
   logic                            val_hit;

   // compare against the item
   assign key_hit = occupied && (key_ff == req_key);
   assign val_hit = occupied && (value_ff == req_value);

   assign link_out.key_seen = link_in.key_seen | key_hit;
   assign link_out.val_seen = link_in.val_seen | val_hit;
   assign val_first         = val_hit & ~link_in.val_seen;

   // append at the tail, or close the gap left by a removed older entry
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl.ins_en && is_tail) begin
         key_in   = req_key;
         value_in = req_value;
      end else if (ctrl.rem_en && link_out.key_seen) begin
         key_in   = nbr_key;
         value_in = nbr_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key_q   = key_ff;
   assign value_q = value_ff;

endmodule

// ===== hdl/ordered_key_value_table_top.sv =====
// ---------------------------------------------------------------------------
// ordered_key_value_table_top: insertion-ordered key/value table
// Row of storage cells with compare-in-place; one operation per item.
// ---------------------------------------------------------------------------
// Usage:
//   Drive req_item and raise start; the item is taken on any clock edge
//   with start high and busy low. busy stays low, so a new item may be
//   given every cycle.
//   Each item gives one result on rsp_item, shown for one cycle with
//   rsp_strobe high, in the cycle after the item is taken (one item per
//   cycle). All cells compare in parallel and the match status ripples
//   along the row within the cycle in which the item is taken.
//   Insert appends at the tail, pop drops the newest entry, remove shifts
//   every newer entry down one cell in the same cycle, find returns the
//   key of the oldest entry holding the value.
//   Reset (synchronous, active high) empties the table; stored pairs are
//   not cleared, only the entry count. The receiver cannot stall: a result
//   not taken in its cycle is gone.
// ---------------------------------------------------------------------------
module ordered_key_value_table_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  okvt_pkg::req_type  req_item,
   output logic               rsp_strobe,
   output okvt_pkg::rsp_type  rsp_item
);

   localparam int D = okvt_pkg::DEPTH;

   logic [okvt_pkg::CNT_BITS-1:0]   count_ff, count_in;
   logic                            rsp_strobe_ff;
   okvt_pkg::rsp_type               rsp_item_ff, rsp_item_in;
   okvt_pkg::ctrl_type              ctrl;
   logic                            accept;

   okvt_pkg::link_type              link [0:D];
   logic [D-1:0]                    val_first;
   logic [okvt_pkg::KEY_BITS-1:0]   cell_key   [0:D-1];
   logic [okvt_pkg::VALUE_BITS-1:0] cell_value [0:D-1];
   logic [okvt_pkg::KEY_BITS-1:0]   found_key;
   logic                            full;
   logic                            empty;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign link[0] = '{key_seen: 1'b0, val_seen: 1'b0};

   // the row of cells, oldest entry in cell 0
   for (genvar i = 0; i < D; i++) begin : g_cell
      localparam int NB = (i + 1 < D) ? i + 1 : i;
      okvt_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (okvt_pkg::CNT_BITS'(i) < count_ff),
         .is_tail   (okvt_pkg::CNT_BITS'(i) == count_ff),
         .req_key   (req_item.key),
         .req_value (req_item.value),
         .nbr_key   (cell_key[NB]),
         .nbr_value (cell_value[NB]),
         .link_in   (link[i]),
         .link_out  (link[i+1]),
         .val_first (val_first[i]),
         .key_q     (cell_key[i]),
         .value_q   (cell_value[i])
      );
   end

   // key of the oldest value match (one-hot select)
   always_comb begin
      found_key = '0;
      for (int i = 0; i < D; i++) begin
         found_key = found_key | (cell_key[i] & {okvt_pkg::KEY_BITS{val_first[i]}});
      end
   end

   assign full  = (count_ff == okvt_pkg::CNT_BITS'(D));
   assign empty = (count_ff == '0);

   // decode the operation
   always_comb begin
      ctrl                = '{ins_en: 1'b0, rem_en: 1'b0};
      count_in            = count_ff;
      rsp_item_in.key_out = '0;
      rsp_item_in.status  = okvt_pkg::ST_INSERTED;
      case (req_item.op)
         okvt_pkg::OP_INSERT: begin
            if (link[D].key_seen) begin
               rsp_item_in.status = okvt_pkg::ST_DUP;
            end else if (full) begin
               rsp_item_in.status = okvt_pkg::ST_FULL;
            end else begin
               ctrl.ins_en        = accept;
               count_in           = count_ff + 1'b1;
               rsp_item_in.status = okvt_pkg::ST_INSERTED;
            end
         end
         okvt_pkg::OP_POP: begin
            if (empty) begin
               rsp_item_in.status = okvt_pkg::ST_EMPTY;
            end else begin
               count_in           = count_ff - 1'b1;
               rsp_item_in.status = okvt_pkg::ST_POPPED;
            end
         end
         okvt_pkg::OP_REMOVE: begin
            if (link[D].key_seen) begin
               ctrl.rem_en        = accept;
               count_in           = count_ff - 1'b1;
               rsp_item_in.status = okvt_pkg::ST_REMOVED;
            end else begin
               rsp_item_in.status = okvt_pkg::ST_KEY_ABSENT;
            end
         end
         okvt_pkg::OP_FIND: begin
            if (link[D].val_seen) begin
               rsp_item_in.key_out = found_key;
               rsp_item_in.status  = okvt_pkg::ST_FOUND;
            end else begin
               rsp_item_in.status  = okvt_pkg::ST_VALUE_ABSENT;
            end
         end
         default: begin
            rsp_item_in.status = okvt_pkg::ST_VALUE_ABSENT;
         end
      endcase
      rsp_item_in.count = count_in;
   end

   // count and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
